// ----- sv/srtm_pkg.sv -----
package srtm_pkg;

    localparam int SRTM_FRAC_BITS    = 16;
    localparam int SRTM_CORDIC_STEPS = 16;

    // configuration register indexes
    localparam logic [2:0] REG_PIVOT_X   = 3'd0;
    localparam logic [2:0] REG_PIVOT_Y   = 3'd1;
    localparam logic [2:0] REG_PIVOT_Z   = 3'd2;
    localparam logic [2:0] REG_SHEAR_X   = 3'd3;
    localparam logic [2:0] REG_SHEAR_Y   = 3'd4;
    localparam logic [2:0] REG_SHEAR_Z   = 3'd5;
    localparam logic [2:0] REG_UNI_SCALE = 3'd6;
    localparam logic [2:0] REG_ROT_MODE  = 3'd7;

    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef struct packed {
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic signed [31:0] translation_x;
        logic signed [31:0] translation_y;
        logic signed [31:0] translation_z;
        logic signed [31:0] rot_a;
        logic signed [31:0] rot_b;
        logic signed [31:0] rot_c;
        logic signed [31:0] rot_d;
    } item_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last_row;
    } row_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // round to nearest, floor shift
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int sh);
        logic signed [63:0] half;
        half = 64'sd1 <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    // arctangent of 2^-k in q30, truncated
    function automatic logic signed [31:0] atan_q30(input int k);
        case (k)
            0:       return 32'sh3243F6A8;
            1:       return 32'sh1DAC6705;
            2:       return 32'sh0FADBAFC;
            3:       return 32'sh07F56EA6;
            4:       return 32'sh03FEAB76;
            5:       return 32'sh01FFD55B;
            6:       return 32'sh00FFFAAA;
            7:       return 32'sh007FFF55;
            8:       return 32'sh003FFFEA;
            9:       return 32'sh001FFFFD;
            10:      return 32'sh000FFFFF;
            11:      return 32'sh0007FFFF;
            12:      return 32'sh0003FFFF;
            13:      return 32'sh0001FFFF;
            14:      return 32'sh0000FFFF;
            15:      return 32'sh00007FFF;
            16:      return 32'sh00003FFF;
            17:      return 32'sh00001FFF;
            18:      return 32'sh00000FFF;
            19:      return 32'sh000007FF;
            20:      return 32'sh000003FF;
            21:      return 32'sh000001FF;
            22:      return 32'sh000000FF;
            23:      return 32'sh0000007F;
            default: return 32'sh00000000;
        endcase
    endfunction

endpackage

// ----- sv/srtm_cordic.sv -----
module srtm_cordic
    import srtm_pkg::*;
#(
    parameter int FRAC_BITS    = SRTM_FRAC_BITS,
    parameter int CORDIC_STEPS = SRTM_CORDIC_STEPS
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] angle,
    output logic signed [31:0] sn,
    output logic signed [31:0] cs
);

    localparam int LB = FRAC_BITS + 1;
    localparam int HW = 32 - LB;
    localparam int PW = HW + 21;
    localparam int RW = HW + 10;
    localparam int SW = 10 + LB;
    localparam int MW = 7 + LB;
    localparam int ZW = 34;

    localparam logic signed [20:0]   RECIP   = 21'sd745655;
    localparam logic signed [SW-1:0] TURN    = SW'(360) <<< LB;
    localparam logic signed [SW-1:0] HALF    = SW'(180) <<< LB;
    localparam logic signed [SW-1:0] QTR     = SW'(90) <<< LB;
    localparam logic [26:0]          DEG_Q32 = 27'd74961321;
    localparam logic signed [ZW-1:0] GAIN    = ZW'(652032874);

    logic signed [HW-1:0]   h;
    logic signed [PW-1:0]   prod1_reg;
    logic signed [HW-1:0]   h1_reg;
    logic [LB-1:0]          lo1_reg;
    logic signed [PW-1:0]   qs;
    logic signed [HW-1:0]   qe;
    logic signed [RW-1:0]   rem2_reg;
    logic [LB-1:0]          lo2_reg;
    logic signed [RW-1:0]   remc;
    logic [8:0]             hm3_reg;
    logic [LB-1:0]          lo3_reg;
    logic signed [SW-1:0]   rpos;
    logic signed [SW-1:0]   rs4_reg;
    logic [MW-1:0]          mag5_reg;
    logic                   sgn5_reg;
    logic                   neg5_reg;
    logic [MW+26:0]         mp6_reg;
    logic                   sgn6_reg;
    logic                   neg6_reg;
    logic [63:0]            zt;
    logic signed [ZW-1:0]   zm;
    logic signed [ZW-1:0]   cx_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0]   cy_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0]   cz_reg [CORDIC_STEPS+1];
    logic                   neg_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0]   xf;
    logic signed [31:0]     sn_reg;
    logic signed [31:0]     cs_reg;

    assign h    = angle[31:LB];
    assign qs   = prod1_reg >>> 28;
    assign qe   = qs[HW-1:0];
    assign remc = (rem2_reg < 0) ? rem2_reg + RW'(360)
                : (rem2_reg >= RW'(360)) ? rem2_reg - RW'(360) : rem2_reg;
    assign rpos = $signed(SW'({hm3_reg, lo3_reg}));
    assign zt   = (64'(mp6_reg) + (64'd1 << (FRAC_BITS + 2))) >> (FRAC_BITS + 3);
    assign zm   = $signed(zt[ZW-1:0]);
    assign xf   = neg_reg[CORDIC_STEPS] ? -cx_reg[CORDIC_STEPS] : cx_reg[CORDIC_STEPS];

    // range reduction: wrap to one turn, then fold into +-90 degrees
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= h * RECIP;
            h1_reg    <= h;
            lo1_reg   <= angle[LB-1:0];

            rem2_reg  <= RW'(h1_reg) - RW'(qe) * RW'(360);
            lo2_reg   <= lo1_reg;

            hm3_reg   <= remc[8:0];
            lo3_reg   <= lo2_reg;

            rs4_reg   <= (hm3_reg >= 9'd180) ? rpos - TURN : rpos;

            if (rs4_reg > QTR)
                mag5_reg <= MW'(HALF - rs4_reg);
            else if (rs4_reg < -QTR)
                mag5_reg <= MW'(HALF + rs4_reg);
            else if (rs4_reg < 0)
                mag5_reg <= MW'(-rs4_reg);
            else
                mag5_reg <= MW'(rs4_reg);
            sgn5_reg  <= rs4_reg[SW-1];
            neg5_reg  <= (rs4_reg > QTR) || (rs4_reg < -QTR);

            mp6_reg   <= mag5_reg * DEG_Q32;
            sgn6_reg  <= sgn5_reg;
            neg6_reg  <= neg5_reg;

            cz_reg[0]  <= sgn6_reg ? -zm : zm;
            cx_reg[0]  <= GAIN;
            cy_reg[0]  <= '0;
            neg_reg[0] <= neg6_reg;

            sn_reg    <= cy_reg[CORDIC_STEPS][31:0];
            cs_reg    <= xf[31:0];
        end
    end

    // one rotation step per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cz_reg[k][ZW-1])
                begin
                    cx_reg[k+1] <= cx_reg[k] - (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] + (cx_reg[k] >>> k);
                    cz_reg[k+1] <= cz_reg[k] - ZW'(atan_q30(k));
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k] + (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] - (cx_reg[k] >>> k);
                    cz_reg[k+1] <= cz_reg[k] + ZW'(atan_q30(k));
                end
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign sn = sn_reg;
    assign cs = cs_reg;

endmodule

// ----- sv/srt_transform_matrix_builder_unit.sv -----
// channel   | direction | handshake                | beat
// ----------+-----------+--------------------------+------------------------------------
// item      | in        | item_valid / item_stall  | scale, translation, rotation words
// row       | out       | row_valid / row_stall    | one row of the transposed matrix
// cfg       | in        | cfg_we                   | cfg_index, cfg_data
//
// one item is taken per cycle into the pipeline unless item_stall is high; each item
// leaves as four row beats, so the sustained rate is set by the row serializer
// rst_n resets valid bits, the serializer and the configuration registers at once
// row_stall holds the serializer; the pipeline freezes only once its last stage is full
module srt_transform_matrix_builder_unit
    import srtm_pkg::*;
#(
    parameter int FRAC_BITS    = SRTM_FRAC_BITS,
    parameter int CORDIC_STEPS = SRTM_CORDIC_STEPS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        row_valid,
    input  logic        row_stall,
    output row_t        row
);

    // angle lanes take CORDIC_STEPS + 8 stages, matrix math 16 more
    localparam int ANG_LAT = CORDIC_STEPS + 8;
    localparam int DEPTH   = ANG_LAT + 16;
    localparam int PQ      = 65 - FRAC_BITS;
    localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;

    // configuration registers
    logic signed [31:0] pivot_reg [3];
    logic signed [31:0] shear_x_reg;
    logic signed [31:0] shear_y_reg;
    logic signed [31:0] shear_z_reg;
    logic signed [31:0] uni_reg;
    logic               mode_reg;

    // pipeline control
    logic [DEPTH-1:0] vld_reg;
    logic             adv;
    logic             load;
    logic             beat;
    logic             hold_v_reg;
    logic             hold_v_next;
    logic [1:0]       row_cnt_reg;
    logic [1:0]       row_cnt_next;

    // angle lanes and the input line that runs beside them
    item_t              in_line_reg [ANG_LAT];
    item_t              ang_item;
    logic signed [31:0] sp, cp, sy, cy, sr, cr;

    // matrix stages
    logic signed [63:0] m1_reg   [4];
    logic signed [63:0] ss_reg   [3];
    logic signed [31:0] cr_line_reg [2];
    logic signed [31:0] sr_line_reg [2];
    logic signed [31:0] rot_line_reg [4][4];
    logic signed [31:0] t_line_reg [12][3];
    logic signed [31:0] s_line_reg [7][3];
    logic signed [31:0] r1_reg   [4];
    logic signed [63:0] m2_reg   [8];
    logic signed [31:0] r2_reg   [8];
    logic signed [31:0] q5_reg   [4];
    logic signed [63:0] pr6_reg  [9];
    logic signed [PQ-1:0] pq7_reg [9];
    logic signed [31:0] r8_reg   [3][3];
    logic signed [63:0] am9_reg  [3][3];
    logic signed [31:0] a10_reg  [3][3];
    logic signed [63:0] tm11_reg [3][3];
    logic signed [31:0] a_line_reg [2][3][3];
    logic signed [PQ-1:0] tr12_reg [3][3];
    logic signed [31:0] a13_reg  [4][3];
    logic signed [63:0] sm14_reg [4][3];
    logic signed [31:0] a14_reg  [4][3];
    logic signed [PQ-1:0] sr15_reg [4][3];
    logic signed [31:0] a15_reg  [4][3];
    logic signed [31:0] f16_reg  [4][3];
    logic signed [31:0] hold_reg [4][3];

    assign ang_item = in_line_reg[ANG_LAT-1];

    // half-angle sine and cosine for pitch, yaw and roll
    srtm_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch
    (
        .clk   (clk),
        .en    (adv),
        .angle (item.rot_a),
        .sn    (sp),
        .cs    (cp)
    );

    srtm_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw
    (
        .clk   (clk),
        .en    (adv),
        .angle (item.rot_b),
        .sn    (sy),
        .cs    (cy)
    );

    srtm_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll
    (
        .clk   (clk),
        .en    (adv),
        .angle (item.rot_c),
        .sn    (sr),
        .cs    (cr)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                pivot_reg[i] <= '0;
            shear_x_reg <= '0;
            shear_y_reg <= '0;
            shear_z_reg <= '0;
            uni_reg     <= ONE32;
            mode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PIVOT_X:   pivot_reg[0] <= cfg_data;
                REG_PIVOT_Y:   pivot_reg[1] <= cfg_data;
                REG_PIVOT_Z:   pivot_reg[2] <= cfg_data;
                REG_SHEAR_X:   shear_x_reg  <= cfg_data;
                REG_SHEAR_Y:   shear_y_reg  <= cfg_data;
                REG_SHEAR_Z:   shear_z_reg  <= cfg_data;
                REG_UNI_SCALE: uni_reg      <= cfg_data;
                REG_ROT_MODE:  mode_reg     <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // whole pipeline moves together; it only holds when the last stage
    // is full and the serializer cannot take it
    assign beat         = hold_v_reg && !row_stall;
    assign load         = vld_reg[DEPTH-1] && (!hold_v_reg || (beat && row_cnt_reg == ROW_LAST));
    assign adv          = !vld_reg[DEPTH-1] || load;
    assign item_stall   = !adv;
    assign hold_v_next  = load ? 1'b1 : (beat && row_cnt_reg == ROW_LAST) ? 1'b0 : hold_v_reg;
    assign row_cnt_next = load ? 2'd0 : beat ? row_cnt_reg + 2'd1 : row_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            hold_v_reg  <= 1'b0;
            row_cnt_reg <= 2'd0;
        end
        else
        begin
            if (adv)
                vld_reg <= {vld_reg[DEPTH-2:0], item_valid};
            hold_v_reg  <= hold_v_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // input line beside the angle lanes
            in_line_reg[0] <= item;
            for (int k = 1; k < ANG_LAT; k++)
                in_line_reg[k] <= in_line_reg[k-1];

            // carried operands
            t_line_reg[0]   <= '{ang_item.translation_x, ang_item.translation_y,
                                  ang_item.translation_z};
            for (int k = 1; k < 12; k++)
                t_line_reg[k] <= t_line_reg[k-1];
            rot_line_reg[0] <= '{ang_item.rot_a, ang_item.rot_b, ang_item.rot_c,
                                  ang_item.rot_d};
            for (int k = 1; k < 4; k++)
                rot_line_reg[k] <= rot_line_reg[k-1];
            for (int k = 1; k < 7; k++)
                s_line_reg[k] <= s_line_reg[k-1];
            cr_line_reg[0] <= cr;
            cr_line_reg[1] <= cr_line_reg[0];
            sr_line_reg[0] <= sr;
            sr_line_reg[1] <= sr_line_reg[0];

            // first half-angle products and per-axis scale
            m1_reg[0] <= cy * sp;
            m1_reg[1] <= sy * cp;
            m1_reg[2] <= cy * cp;
            m1_reg[3] <= sy * sp;
            ss_reg[0] <= ang_item.scale_x * uni_reg;
            ss_reg[1] <= ang_item.scale_y * uni_reg;
            ss_reg[2] <= ang_item.scale_z * uni_reg;

            for (int k = 0; k < 4; k++)
                r1_reg[k] <= 32'(rnd_shift(m1_reg[k], 30));
            for (int i = 0; i < 3; i++)
                s_line_reg[0][i] <= sat32(rnd_shift(ss_reg[i], FRAC_BITS));

            // second products against roll
            m2_reg[0] <= r1_reg[0] * cr_line_reg[1];
            m2_reg[1] <= r1_reg[1] * sr_line_reg[1];
            m2_reg[2] <= r1_reg[1] * cr_line_reg[1];
            m2_reg[3] <= r1_reg[0] * sr_line_reg[1];
            m2_reg[4] <= r1_reg[2] * sr_line_reg[1];
            m2_reg[5] <= r1_reg[3] * cr_line_reg[1];
            m2_reg[6] <= r1_reg[2] * cr_line_reg[1];
            m2_reg[7] <= r1_reg[3] * sr_line_reg[1];

            for (int k = 0; k < 8; k++)
                r2_reg[k] <= 32'(rnd_shift(m2_reg[k], 30));

            // quaternion x y z w, or the raw words in quaternion mode
            if (mode_reg)
            begin
                for (int k = 0; k < 4; k++)
                    q5_reg[k] <= rot_line_reg[3][k];
            end
            else
            begin
                q5_reg[0] <= 32'(rnd_shift(64'(r2_reg[0]) + 64'(r2_reg[1]), 30 - FRAC_BITS));
                q5_reg[1] <= 32'(rnd_shift(64'(r2_reg[2]) - 64'(r2_reg[3]), 30 - FRAC_BITS));
                q5_reg[2] <= 32'(rnd_shift(64'(r2_reg[4]) - 64'(r2_reg[5]), 30 - FRAC_BITS));
                q5_reg[3] <= 32'(rnd_shift(64'(r2_reg[6]) + 64'(r2_reg[7]), 30 - FRAC_BITS));
            end

            // quaternion cross products: yy zz xx xy wz xz wy yz wx
            pr6_reg[0] <= q5_reg[1] * q5_reg[1];
            pr6_reg[1] <= q5_reg[2] * q5_reg[2];
            pr6_reg[2] <= q5_reg[0] * q5_reg[0];
            pr6_reg[3] <= q5_reg[0] * q5_reg[1];
            pr6_reg[4] <= q5_reg[3] * q5_reg[2];
            pr6_reg[5] <= q5_reg[0] * q5_reg[2];
            pr6_reg[6] <= q5_reg[3] * q5_reg[1];
            pr6_reg[7] <= q5_reg[1] * q5_reg[2];
            pr6_reg[8] <= q5_reg[3] * q5_reg[0];

            for (int k = 0; k < 9; k++)
                pq7_reg[k] <= PQ'(rnd_shift(pr6_reg[k], FRAC_BITS));

            // rotation matrix
            r8_reg[0][0] <= sat32(ONE64 - ((64'(pq7_reg[0]) + 64'(pq7_reg[1])) <<< 1));
            r8_reg[0][1] <= sat32((64'(pq7_reg[3]) + 64'(pq7_reg[4])) <<< 1);
            r8_reg[0][2] <= sat32((64'(pq7_reg[5]) - 64'(pq7_reg[6])) <<< 1);
            r8_reg[1][0] <= sat32((64'(pq7_reg[3]) - 64'(pq7_reg[4])) <<< 1);
            r8_reg[1][1] <= sat32(ONE64 - ((64'(pq7_reg[1]) + 64'(pq7_reg[2])) <<< 1));
            r8_reg[1][2] <= sat32((64'(pq7_reg[7]) + 64'(pq7_reg[8])) <<< 1);
            r8_reg[2][0] <= sat32((64'(pq7_reg[5]) + 64'(pq7_reg[6])) <<< 1);
            r8_reg[2][1] <= sat32((64'(pq7_reg[7]) - 64'(pq7_reg[8])) <<< 1);
            r8_reg[2][2] <= sat32(ONE64 - ((64'(pq7_reg[0]) + 64'(pq7_reg[2])) <<< 1));

            // scale rows, then pivot terms of the translation row
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    am9_reg[i][j]  <= s_line_reg[6][i] * r8_reg[i][j];
                    a10_reg[i][j]  <= sat32(rnd_shift(am9_reg[i][j], FRAC_BITS));
                    tm11_reg[i][j] <= pivot_reg[i] * a10_reg[i][j];
                    tr12_reg[i][j] <= PQ'(rnd_shift(tm11_reg[i][j], FRAC_BITS));
                end
            end
            a_line_reg[0] <= a10_reg;
            a_line_reg[1] <= a_line_reg[0];

            for (int i = 0; i < 3; i++)
                a13_reg[i] <= a_line_reg[1][i];
            for (int j = 0; j < 3; j++)
                a13_reg[3][j] <= sat32(64'(pivot_reg[j]) + 64'(t_line_reg[11][j])
                                       - 64'(tr12_reg[0][j]) - 64'(tr12_reg[1][j])
                                       - 64'(tr12_reg[2][j]));

            // shear
            for (int i = 0; i < 4; i++)
            begin
                sm14_reg[i][0] <= a13_reg[i][1] * shear_x_reg;
                sm14_reg[i][1] <= a13_reg[i][0] * shear_y_reg;
                sm14_reg[i][2] <= a13_reg[i][0] * shear_z_reg;
                for (int j = 0; j < 3; j++)
                begin
                    sr15_reg[i][j] <= PQ'(rnd_shift(sm14_reg[i][j], FRAC_BITS));
                    f16_reg[i][j]  <= sat32(64'(a15_reg[i][j]) + 64'(sr15_reg[i][j]));
                end
            end
            a14_reg <= a13_reg;
            a15_reg <= a14_reg;
        end
    end

    // serializer holds one finished matrix
    always_ff @(posedge clk)
    begin
        if (load)
            hold_reg <= f16_reg;
    end

    assign row_valid = hold_v_reg;

    always_comb
    begin
        row.row_index = row_cnt_reg;
        row.last_row  = (row_cnt_reg == ROW_LAST);
        if (row_cnt_reg == ROW_LAST)
        begin
            row.col0 = '0;
            row.col1 = '0;
            row.col2 = '0;
            row.col3 = ONE32;
        end
        else
        begin
            row.col0 = hold_reg[0][row_cnt_reg];
            row.col1 = hold_reg[1][row_cnt_reg];
            row.col2 = hold_reg[2][row_cnt_reg];
            row.col3 = hold_reg[3][row_cnt_reg];
        end
    end

endmodule

// ----- sv/srtm_checker.sv -----
module srtm_checker
    import srtm_pkg::*;
#(
    parameter int FRAC_BITS = SRTM_FRAC_BITS
)
(
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_stall,
    input logic row_valid,
    input logic row_stall,
    input row_t row
);

    // a stalled row beat holds
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_stall |=> row_valid && $stable(row))
        else $error("row beat changed under stall");

    // rows of one matrix follow in order without gaps
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_stall && row.row_index != ROW_LAST
        |=> row_valid && row.row_index == $past(row.row_index) + 2'd1)
        else $error("row order broken");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> row.last_row == (row.row_index == ROW_LAST))
        else $error("last_row flag mismatch");

    a_last_const: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row.last_row |-> row.col0 == 32'sd0 && row.col1 == 32'sd0
            && row.col2 == 32'sd0 && row.col3 == (32'sd1 <<< FRAC_BITS))
        else $error("bottom row not identity");

    // input backs up only while a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |-> row_valid)
        else $error("input stalled with no row pending");

endmodule

bind srt_transform_matrix_builder_unit srtm_checker #(.FRAC_BITS(FRAC_BITS)) u_srtm_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .row_valid  (row_valid),
    .row_stall  (row_stall),
    .row        (row)
);
